// ===== hdl/great_circle_bearing_assert.svh =====
// ----------------------------------------------------------------------------
// Great-circle bearing: assertion macros
// Shared property wrappers; they sample on clk_i and stay quiet in reset.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_BEARING_ASSERT_SVH
`define GREAT_CIRCLE_BEARING_ASSERT_SVH

// Same-cycle implication
`define GCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Great-circle bearing: package
// Widths, fixed-point constants, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package gcb_pkg;

  // Field widths
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int LAT_W           = 24;
  localparam int LON_W           = 25;
  localparam int BEAR_W          = 25;
  localparam int IN_TDATA_W      = 56;
  localparam int OUT_TDATA_W     = 32;
  localparam int CFG_W           = 25;
  localparam int CFG_IDX_W       = 1;

  // Internal widths
  localparam int ANG_W      = 26;              // wrapped angle, input format
  localparam int MAG_W      = ANG_W - 1;       // folded magnitude
  localparam int Z_W        = 42;              // angle accumulator, Q32 degrees
  localparam int ROT_XY_W   = 34;              // rotation CORDIC x/y, Q30
  localparam int TRIG_W     = 32;              // sine/cosine out, Q30
  localparam int PROD_W     = 2 * TRIG_W;
  localparam int NUM_W      = 34;              // atan2 terms
  localparam int VEC_XY_W   = 36;              // vectoring CORDIC x/y
  localparam int BEAR_RAW_W = 26;
  localparam int SH_W       = 5;
  localparam int LANES      = 3;

  localparam int Q_SHIFT  = 32 - ANGLE_FRAC_BITS;
  localparam int FRAC_XY  = 30;
  localparam int NORM_MSB = 29;

  localparam longint ONE_DEG_Q32 = 64'sd1 <<< 32;
  localparam longint DEG_PER_RAD = 64'sd246083499208;

  localparam logic signed [ANG_W-1:0] DEG180_A = ANG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] DEG360_A = ANG_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [MAG_W-1:0]        DEG90_M  = MAG_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [MAG_W-1:0]        DEG180_M = MAG_W'(180 << ANGLE_FRAC_BITS);

  localparam logic signed [ROT_XY_W-1:0] CORDIC_INV_GAIN = ROT_XY_W'(652032874);
  localparam logic signed [ROT_XY_W-1:0] UNIT_Q30        = ROT_XY_W'(1 << FRAC_XY);

  localparam logic signed [Z_W-1:0] Z_180   = Z_W'(180 * ONE_DEG_Q32);
  localparam logic signed [Z_W-1:0] Z_360   = Z_W'(360 * ONE_DEG_Q32);
  localparam logic signed [Z_W-1:0] Z_HALF  = Z_W'(64'sd1 <<< (Q_SHIFT - 1));
  localparam logic [BEAR_RAW_W-1:0] BEAR_LIM = BEAR_RAW_W'(360 << ANGLE_FRAC_BITS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LAT = 1'b0,
    REG_TARGET_LON = 1'b1
  } cfg_reg_e;

  // Per-lane fold flags of the sine/cosine unit
  typedef struct packed {
    logic neg;    // sine negated
    logic flip;   // cosine negated
    logic zero;   // folded angle exactly 0
    logic right;  // folded angle exactly 90
  } rot_flags_t;

  // Restoring long division of non-negative values, table build only
  function automatic longint udiv_nn(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, Q32, truncated arctangent series
  function automatic logic signed [Z_W-1:0] atan_q32(input int unsigned idx);
    longint      acc;
    longint      t;
    int unsigned s;
    acc = 0;
    if (idx == 0) begin
      acc = 45 * ONE_DEG_Q32;
    end else begin
      for (int unsigned k = 0; k < 20; k++) begin
        s = (2 * k + 1) * idx;
        if (s < 40) begin
          t = udiv_nn(DEG_PER_RAD >>> s, longint'(2 * k + 1));
          acc = ((k & 1) != 0) ? acc - t : acc + t;
        end
      end
    end
    return acc[Z_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/great_circle_bearing.sv =====
// ----------------------------------------------------------------------------
// Great-circle bearing: top level
// Initial bearing from an observer position to a configured target point.
// ----------------------------------------------------------------------------
// Takes one observer position per clock and returns the initial great-circle
// bearing toward the target held in the two configuration registers, in
// degrees with 16 fraction bits, 0 up to below 360, clockwise from north.
// The result passes through the two CORDIC pipelines (sine/cosine, then
// atan2) plus the multiply, normalize and rounding stages. Throughput is
// one beat per cycle; when the output beat is not taken the whole pipeline
// holds. tuser flags a beat whose bearing is undefined (observer at the
// target or its antipode), with bearing 0.
`default_nettype none

`include "great_circle_bearing_assert.svh"

module great_circle_bearing #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input beats
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // observer_latitude [23:0], observer_longitude [48:24], zero pad
  input  logic [gcb_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // Result beats
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // bearing [24:0], zero pad
  output logic [gcb_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // bearing_undefined [0]
  output logic                                  m_axis_tuser,
  // Configuration writes
  input  logic                                  cfg_we_i,
  input  logic [gcb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [gcb_pkg::CFG_W-1:0]             cfg_data_i
);
  import gcb_pkg::*;

  logic                     pipe_en;
  logic [LAT_W-1:0]         tlat_q;
  logic [LON_W-1:0]         tlon_q;

  // Stage A: angle setup
  logic                     v_a_q;
  logic signed [ANG_W-1:0]  lat_a_q, tlat_a_q, dlon_a_q;
  logic signed [ANG_W-1:0]  dlon_raw, dlon_wr;
  logic signed [ANG_W-1:0]  angles [LANES];

  // Sine/cosine results
  logic                     v_r;
  logic signed [TRIG_W-1:0] cos_r [LANES];
  logic signed [TRIG_W-1:0] sin_r [LANES];

  // Products
  logic                     v_p1_q, v_p2_q, v_p3_q;
  logic signed [PROD_W-1:0] prod_num, prod_t, prod_a, prod_b, prod_diff;
  logic signed [NUM_W-1:0]  num_p1_q, num_p2_q, num_p3_q, den_p3_q;
  logic signed [TRIG_W-1:0] t_p1_q, sl_p1_q;
  logic signed [PROD_W-1:0] pa_p1_q, pa_p2_q, pb_p2_q;

  // Normalize
  logic                       v_n1_q, v_n2_q, v_n3_q;
  logic                       und_n1_q, und_n2_q, und_n3_q;
  logic [NUM_W-1:0]           ax, ay;
  logic signed [NUM_W-1:0]    num_n1_q, den_n1_q, num_n2_q, den_n2_q;
  logic [NUM_W-1:0]           mx_n1_q;
  logic [SH_W-1:0]            pos, sh, sh_n2_q;
  logic signed [VEC_XY_W-1:0] dx, dy;
  logic signed [VEC_XY_W-1:0] x_n3_q, y_n3_q;
  logic signed [Z_W-1:0]      z_n3_q;

  // atan2 and output
  logic                        v_v, und_v;
  logic signed [Z_W-1:0]       z_v, z_wr, z_rnd;
  logic                        v_f1_q, und_f1_q;
  logic [BEAR_RAW_W-1:0]       r_f1_q;
  logic                        out_vld_q, out_und_q;
  logic [BEAR_W-1:0]           bear_q;
  logic [8:0]                  valid_chain;

  // Global advance: output register free or being drained
  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlat_q <= LAT_W'(1403999);
      tlon_q <= LON_W'(2609862);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TARGET_LAT: tlat_q <= cfg_data_i[LAT_W-1:0];
        REG_TARGET_LON: tlon_q <= cfg_data_i[LON_W-1:0];
        default: ;
      endcase
    end
  end

  // Longitude difference wrapped into [-180, 180)
  always_comb begin
    dlon_raw = ANG_W'(signed'(tlon_q)) - ANG_W'(signed'(s_axis_tdata[LAT_W +: LON_W]));
    if (dlon_raw >= DEG180_A) begin
      dlon_wr = dlon_raw - DEG360_A;
    end else if (dlon_raw < -DEG180_A) begin
      dlon_wr = dlon_raw + DEG360_A;
    end else begin
      dlon_wr = dlon_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      lat_a_q  <= ANG_W'(signed'(s_axis_tdata[LAT_W-1:0]));
      tlat_a_q <= ANG_W'(signed'(tlat_q));
      dlon_a_q <= dlon_wr;
    end
  end

  assign angles[0] = lat_a_q;
  assign angles[1] = tlat_a_q;
  assign angles[2] = dlon_a_q;

  gcb_rot_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v_a_q),
    .angle_i (angles),
    .valid_o (v_r),
    .cos_o   (cos_r),
    .sin_o   (sin_r)
  );

  // P1: sin(dlon)cos(tlat), cos(tlat)cos(dlon), cos(lat)sin(tlat)
  assign prod_num = sin_r[2] * cos_r[1];
  assign prod_t   = cos_r[1] * cos_r[2];
  assign prod_a   = cos_r[0] * sin_r[1];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      num_p1_q <= prod_num[FRAC_XY +: NUM_W];
      t_p1_q   <= prod_t[FRAC_XY +: TRIG_W];
      pa_p1_q  <= prod_a;
      sl_p1_q  <= sin_r[0];
    end
  end

  // P2: sin(lat) times the shifted cosine product
  assign prod_b = sl_p1_q * t_p1_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      num_p2_q <= num_p1_q;
      pa_p2_q  <= pa_p1_q;
      pb_p2_q  <= prod_b;
    end
  end

  // P3: denominator
  assign prod_diff = pa_p2_q - pb_p2_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      num_p3_q <= num_p2_q;
      den_p3_q <= prod_diff[FRAC_XY +: NUM_W];
    end
  end

  // N1: magnitudes and zero test
  assign ax = den_p3_q[NUM_W-1] ? NUM_W'(-den_p3_q) : NUM_W'(den_p3_q);
  assign ay = num_p3_q[NUM_W-1] ? NUM_W'(-num_p3_q) : NUM_W'(num_p3_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      num_n1_q <= num_p3_q;
      den_n1_q <= den_p3_q;
      mx_n1_q  <= (ax > ay) ? ax : ay;
      und_n1_q <= (num_p3_q == '0) && (den_p3_q == '0);
    end
  end

  // N2: shift count that brings the larger magnitude up to 2^29
  always_comb begin
    pos = '0;
    for (int b = 0; b < NORM_MSB; b++) begin
      if (mx_n1_q[b]) pos = SH_W'(b);
    end
    if (mx_n1_q[NUM_W-1:NORM_MSB] != '0 || mx_n1_q == '0) begin
      sh = '0;
    end else begin
      sh = SH_W'(NORM_MSB) - pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      num_n2_q <= num_n1_q;
      den_n2_q <= den_n1_q;
      sh_n2_q  <= sh;
      und_n2_q <= und_n1_q;
    end
  end

  // N3: scale, then move into the right half plane
  assign dx = VEC_XY_W'(den_n2_q) <<< sh_n2_q;
  assign dy = VEC_XY_W'(num_n2_q) <<< sh_n2_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      if (dx[VEC_XY_W-1]) begin
        x_n3_q <= -dx;
        y_n3_q <= -dy;
        z_n3_q <= Z_180;
      end else begin
        x_n3_q <= dx;
        y_n3_q <= dy;
        z_n3_q <= '0;
      end
      und_n3_q <= und_n2_q;
    end
  end

  gcb_vec_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v_n3_q),
    .undef_i (und_n3_q),
    .x_i     (x_n3_q),
    .y_i     (y_n3_q),
    .z_i     (z_n3_q),
    .valid_o (v_v),
    .undef_o (und_v),
    .z_o     (z_v)
  );

  // F1: wrap to [0, 360) and round half up
  assign z_wr  = z_v[Z_W-1] ? z_v + Z_360 : z_v;
  assign z_rnd = z_wr + Z_HALF;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r_f1_q   <= z_rnd[Q_SHIFT +: BEAR_RAW_W];
      und_f1_q <= und_v;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_und_q <= und_f1_q;
      if (und_f1_q) begin
        bear_q <= '0;
      end else if (r_f1_q >= BEAR_LIM) begin
        bear_q <= BEAR_W'(r_f1_q - BEAR_LIM);
      end else begin
        bear_q <= BEAR_W'(r_f1_q);
      end
    end
  end

  // Valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q     <= 1'b0;
      v_p1_q    <= 1'b0;
      v_p2_q    <= 1'b0;
      v_p3_q    <= 1'b0;
      v_n1_q    <= 1'b0;
      v_n2_q    <= 1'b0;
      v_n3_q    <= 1'b0;
      v_f1_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      v_a_q     <= s_axis_tvalid;
      v_p1_q    <= v_r;
      v_p2_q    <= v_p1_q;
      v_p3_q    <= v_p2_q;
      v_n1_q    <= v_p3_q;
      v_n2_q    <= v_n1_q;
      v_n3_q    <= v_n2_q;
      v_f1_q    <= v_v;
      out_vld_q <= v_f1_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - BEAR_W)'(0), bear_q};
  assign m_axis_tuser  = out_und_q;

  assign valid_chain = {v_a_q, v_p1_q, v_p2_q, v_p3_q, v_n1_q, v_n2_q, v_n3_q,
                        v_f1_q, out_vld_q};

  // Checks
  `GCB_ASSERT_IMP(a_undef_zero, m_axis_tvalid && m_axis_tuser, bear_q == '0, "undefined bearing not zero")
  `GCB_ASSERT_IMP(a_bear_range, m_axis_tvalid, BEAR_RAW_W'(bear_q) < BEAR_LIM, "bearing not below 360")
  `GCB_ASSERT_NXT(a_stall_hold, !pipe_en, $stable(valid_chain), "pipeline moved while stalled")
  `GCB_ASSERT_IMP(a_ready_drain, m_axis_tready, s_axis_tready, "input blocked while output drains")

endmodule

`default_nettype wire

// ===== hdl/gcb_rot_cordic.sv =====
// ----------------------------------------------------------------------------
// Great-circle bearing: sine/cosine unit
// Three lanes of pipelined rotation CORDIC, one stage per iteration, with
// quadrant fold on entry and sign fix on exit.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_rot_cordic #(
  parameter int STAGES = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [gcb_pkg::ANG_W-1:0]   angle_i [gcb_pkg::LANES],
  output logic                               valid_o,
  output logic signed [gcb_pkg::TRIG_W-1:0]  cos_o   [gcb_pkg::LANES],
  output logic signed [gcb_pkg::TRIG_W-1:0]  sin_o   [gcb_pkg::LANES]
);
  import gcb_pkg::*;

  logic [STAGES:0] vld_q;
  logic            out_vld_q;

  // Valid chain: fold stage, iterations, output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[STAGES-1:0], valid_i};
      out_vld_q <= vld_q[STAGES];
    end
  end

  assign valid_o = out_vld_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [MAG_W-1:0]           mag;
    logic [MAG_W-1:0]           m;
    rot_flags_t                 fl_d;
    logic signed [ROT_XY_W-1:0] x_q  [STAGES+1];
    logic signed [ROT_XY_W-1:0] y_q  [STAGES+1];
    logic signed [Z_W-1:0]      z_q  [STAGES+1];
    rot_flags_t                 fl_q [STAGES+1];
    logic signed [ROT_XY_W-1:0] c;
    logic signed [ROT_XY_W-1:0] s;
    logic signed [TRIG_W-1:0]   cos_q;
    logic signed [TRIG_W-1:0]   sin_q;

    // Fold into 0..90 degrees
    always_comb begin
      mag = angle_i[l][ANG_W-1] ? MAG_W'(-angle_i[l]) : MAG_W'(angle_i[l]);
      fl_d.neg = angle_i[l][ANG_W-1];
      if (mag > DEG90_M) begin
        m         = DEG180_M - mag;
        fl_d.flip = 1'b1;
      end else begin
        m         = mag;
        fl_d.flip = 1'b0;
      end
      fl_d.zero  = (m == '0);
      fl_d.right = (m == DEG90_M);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0]  <= CORDIC_INV_GAIN;
        y_q[0]  <= '0;
        z_q[0]  <= Z_W'(m) << Q_SHIFT;
        fl_q[0] <= fl_d;
      end
    end

    // One rotation per stage, steering z toward zero
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [Z_W-1:0] AT = atan_q32(i);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_q[i][Z_W-1]) begin
            x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
            z_q[i+1] <= z_q[i] - AT;
          end else begin
            x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
            z_q[i+1] <= z_q[i] + AT;
          end
          fl_q[i+1] <= fl_q[i];
        end
      end
    end

    // Exact axes and quadrant signs
    always_comb begin
      if (fl_q[STAGES].zero) begin
        c = UNIT_Q30;
        s = '0;
      end else if (fl_q[STAGES].right) begin
        c = '0;
        s = UNIT_Q30;
      end else begin
        c = x_q[STAGES];
        s = y_q[STAGES];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cos_q <= TRIG_W'(fl_q[STAGES].flip ? -c : c);
        sin_q <= TRIG_W'(fl_q[STAGES].neg ? -s : s);
      end
    end

    assign cos_o[l] = cos_q;
    assign sin_o[l] = sin_q;
  end

endmodule

`default_nettype wire

// ===== hdl/gcb_vec_cordic.sv =====
// ----------------------------------------------------------------------------
// Great-circle bearing: atan2 unit
// Pipelined vectoring CORDIC, one stage per iteration; drives y to zero and
// accumulates the angle in z.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_vec_cordic #(
  parameter int STAGES = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               undef_i,
  input  logic signed [gcb_pkg::VEC_XY_W-1:0] x_i,
  input  logic signed [gcb_pkg::VEC_XY_W-1:0] y_i,
  input  logic signed [gcb_pkg::Z_W-1:0]      z_i,
  output logic                               valid_o,
  output logic                               undef_o,
  output logic signed [gcb_pkg::Z_W-1:0]      z_o
);
  import gcb_pkg::*;

  logic [STAGES-1:0]          vld_q;
  logic [STAGES-1:0]          und_q;
  logic signed [VEC_XY_W-1:0] x_p [STAGES+1];
  logic signed [VEC_XY_W-1:0] y_p [STAGES+1];
  logic signed [Z_W-1:0]      z_p [STAGES+1];

  // Valid and undefined flag ride alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      und_q <= {und_q[STAGES-2:0], undef_i};
    end
  end

  assign x_p[0] = x_i;
  assign y_p[0] = y_i;
  assign z_p[0] = z_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] AT = atan_q32(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_p[i][VEC_XY_W-1]) begin
          x_p[i+1] <= x_p[i] + (y_p[i] >>> i);
          y_p[i+1] <= y_p[i] - (x_p[i] >>> i);
          z_p[i+1] <= z_p[i] + AT;
        end else begin
          x_p[i+1] <= x_p[i] - (y_p[i] >>> i);
          y_p[i+1] <= y_p[i] + (x_p[i] >>> i);
          z_p[i+1] <= z_p[i] - AT;
        end
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign undef_o = und_q[STAGES-1];
  assign z_o     = z_p[STAGES];

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Great-circle bearing: testbench
// Drives observer positions through the stream port under several target
// settings and checks each result beat against an in-bench bearing predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gcb_pkg::*;

  localparam longint ONE_Q32  = 64'sd1 <<< 32;
  localparam longint UNIT_XY  = 64'sd1 <<< 30;
  localparam longint INV_GAIN = 64'sd652032874;
  localparam int     STAGES   = 24;
  localparam int     LATENCY  = 2 * STAGES + 11;
  localparam int     WATCHDOG = 5000;

  typedef struct packed {
    logic [BEAR_W-1:0] bearing;
    logic              undef;
  } bearing_t;

  typedef struct {
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
    bit                typed;
    bearing_t          res;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  // Bench copy of the target registers
  logic [LAT_W-1:0] tgt_lat = LAT_W'(1403999);
  logic [LON_W-1:0] tgt_lon = LON_W'(2609862);

  bearing_t bearing_q[$];
  int       fails = 0;
  int       idle_cycles = 0;
  bit       no_idle = 1'b0;
  int       sink_hold = 0;

  great_circle_bearing dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_half(longint a);
    longint full;
    full = 360 * ONE_Q32;
    a = a % full;
    if (a < 0) a += full;
    if (a >= 180 * ONE_Q32) a -= full;
    return a;
  endfunction

  function automatic longint atan_deg(int i);
    longint acc;
    longint t;
    int     s;
    acc = 0;
    if (i == 0) return 45 * ONE_Q32;
    for (int k = 0; k < 40; k++) begin
      s = (2 * k + 1) * i;
      if (s >= 40) break;
      t = (DEG_PER_RAD >>> s) / longint'(2 * k + 1);
      acc = (k % 2 == 1) ? acc - t : acc + t;
    end
    return acc;
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint a, m, x, y, z, xs, ys;
    bit     neg, flip;
    a = wrap_half(ang);
    neg = a < 0;
    m = neg ? -a : a;
    flip = 1'b0;
    if (m > 90 * ONE_Q32) begin
      m = 180 * ONE_Q32 - m;
      flip = 1'b1;
    end
    if (m == 0) begin
      x = UNIT_XY; y = 0;
    end else if (m == 90 * ONE_Q32) begin
      x = 0; y = UNIT_XY;
    end else begin
      x = INV_GAIN; y = 0; z = m;
      for (int i = 0; i < STAGES; i++) begin
        xs = asr(x, i); ys = asr(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_deg(i);
        end else begin
          x += ys; y -= xs; z += atan_deg(i);
        end
      end
    end
    c = flip ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic bearing_t predict_bearing(logic [LAT_W-1:0] olat, logic [LON_W-1:0] olon);
    longint   lat, tlat, dlon, cl, sl, ct, st, cd, sd, num, den, t;
    longint   x, y, z, ax, ay, mx, xs, ys, full, r;
    bearing_t res;
    full = 360 * ONE_Q32;
    lat  = longint'($signed(olat)) * 65536;
    tlat = longint'($signed(tgt_lat)) * 65536;
    dlon = (longint'($signed(tgt_lon)) - longint'($signed(olon))) * 65536;
    sin_cos(lat, cl, sl);
    sin_cos(tlat, ct, st);
    sin_cos(dlon, cd, sd);
    num = asr(sd * ct, 30);
    t   = asr(ct * cd, 30);
    den = asr(cl * st - sl * t, 30);
    if (num == 0 && den == 0) begin
      res.bearing = '0;
      res.undef = 1'b1;
      return res;
    end
    x = den; y = num;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    mx = ax > ay ? ax : ay;
    while (mx < (64'sd1 <<< 29)) begin
      x *= 2; y *= 2; mx *= 2;
    end
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 180 * ONE_Q32;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = asr(x, i); ys = asr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_deg(i);
      end else begin
        x -= ys; y += xs; z -= atan_deg(i);
      end
    end
    z = z % full;
    if (z < 0) z += full;
    r = (z + (64'sd1 <<< 15)) >>> 16;
    if (r >= (64'sd360 <<< 16)) r -= 64'sd360 <<< 16;
    res.bearing = r[BEAR_W-1:0];
    res.undef = 1'b0;
    return res;
  endfunction

  // ------------------------------------------------------------------ helpers
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one input beat, record its expectation once accepted
  task automatic send_pos(logic [LAT_W-1:0] lat, logic [LON_W-1:0] lon,
                          bit typed, bearing_t res);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, lon, lat};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    bearing_q.push_back(typed ? res : predict_bearing(lat, lon));
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TARGET_LAT) tgt_lat = val[LAT_W-1:0];
    else tgt_lon = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (bearing_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [LAT_W-1:0] rand_lat();
    if ($urandom_range(0, 9) == 0) return LAT_W'($urandom);
    return LAT_W'(int'($urandom_range(0, 2 * 5898240)) - 5898240);
  endfunction

  function automatic logic [LON_W-1:0] rand_lon();
    if ($urandom_range(0, 9) == 0) return LON_W'($urandom);
    return LON_W'(int'($urandom_range(0, 2 * 11796480)) - 11796480);
  endfunction

  task automatic random_run(int n);
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    bearing_t         none;
    int               r;
    none = '0;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      lat = rand_lat();
      lon = rand_lon();
      // a few beats at the target, its antipode, or a full turn away
      if (r < 3) begin
        lat = tgt_lat; lon = tgt_lon;
      end else if (r < 6) begin
        lat = -tgt_lat; lon = tgt_lon - LON_W'(11796480);
      end else if (r < 8) begin
        lat = tgt_lat; lon = tgt_lon + LON_W'(23592960);
      end
      send_pos(lat, lon, 1'b0, none);
    end
  endtask

  // ---------------------------------------------------------------- result sink
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      int g;
      g = pick_gap();
      if (g == 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        sink_hold <= g - 1;
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (bearing_q.size() == 0) begin
        $error("unexpected result beat: bearing %0d undefined %0b",
               m_axis_tdata[BEAR_W-1:0], m_axis_tuser);
        fails++;
      end else begin
        bearing_t want;
        want = bearing_q.pop_front();
        if (m_axis_tdata[BEAR_W-1:0] !== want.bearing) begin
          $error("bearing: expected %0d, got %0d", want.bearing, m_axis_tdata[BEAR_W-1:0]);
          fails++;
        end
        if (m_axis_tuser !== want.undef) begin
          $error("bearing_undefined: expected %0b, got %0b", want.undef, m_axis_tuser);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ----------------------------------------------------------------- sequence
  initial begin
    dir_row_t rows[$];
    bearing_t undef_res;
    undef_res.bearing = '0;
    undef_res.undef = 1'b1;

    // Directed beats under the reset target
    rows.push_back('{LAT_W'(1403999), LON_W'(2609862), 1'b1, undef_res});     // at target
    rows.push_back('{-LAT_W'(1403999), LON_W'(-9186618), 1'b1, undef_res});   // antipode
    // longitude field wraps at 512 degrees, so this is not the target
    rows.push_back('{LAT_W'(1403999), LON_W'(2609862 - 23592960), 1'b0, '0});
    rows.push_back('{LAT_W'(0), LON_W'(0), 1'b0, '0});
    rows.push_back('{LAT_W'(5898240), LON_W'(0), 1'b0, '0});                  // north pole
    rows.push_back('{-LAT_W'(5898240), LON_W'(0), 1'b0, '0});                 // south pole
    rows.push_back('{LAT_W'(0), LON_W'(11796480), 1'b0, '0});
    rows.push_back('{LAT_W'(0), -LON_W'(11796480), 1'b0, '0});
    rows.push_back('{LAT_W'(5898240), LON_W'(11796480), 1'b0, '0});
    rows.push_back('{-LAT_W'(5898240), -LON_W'(11796480), 1'b0, '0});
    rows.push_back('{LAT_W'(1403999), LON_W'(0), 1'b0, '0});                  // same latitude
    rows.push_back('{LAT_W'(0), LON_W'(2609862), 1'b0, '0});                  // same meridian
    rows.push_back('{LAT_W'(24'h7FFFFF), LON_W'(0), 1'b0, '0});               // past the pole
    rows.push_back('{LAT_W'(24'h800000), LON_W'(0), 1'b0, '0});
    rows.push_back('{LAT_W'(0), LON_W'(25'h0FFFFFF), 1'b0, '0});              // wide longitude
    rows.push_back('{LAT_W'(0), LON_W'(25'h1000000), 1'b0, '0});
    rows.push_back('{LAT_W'(24'hFFFFFF), LON_W'(25'h1FFFFFF), 1'b0, '0});
    rows.push_back('{LAT_W'(2949120), LON_W'(2609862 + 5898240), 1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    foreach (rows[k]) send_pos(rows[k].lat, rows[k].lon, rows[k].typed, rows[k].res);
    random_run(130);
    drain();

    // Target extremes, zero, then random targets
    for (int ph = 0; ph < 6; ph++) begin
      logic [CFG_W-1:0] vlat, vlon;
      case (ph)
        0: begin vlat = CFG_W'(-5832704); vlon = CFG_W'(-11796480); end
        1: begin vlat = CFG_W'(5832704);  vlon = CFG_W'(11796480);  end
        2: begin vlat = '0;               vlon = '0;                end
        default: begin
          vlat = CFG_W'(int'($urandom_range(0, 2 * 5832704)) - 5832704);
          vlon = CFG_W'(int'($urandom_range(0, 2 * 11796480)) - 11796480);
        end
      endcase
      write_reg(REG_TARGET_LAT, vlat);
      write_reg(REG_TARGET_LON, vlon);
      random_run(125);
      drain();
    end

    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
